// File: sv/ipr_pkg.sv
`default_nettype none
package ipr_pkg;

  localparam int DATA_W   = 32;
  localparam int GAIN_W   = 24;
  localparam int LIMIT_W  = 31;
  localparam int Q_SHIFT  = 16;
  localparam int INDEX_W  = 3;

  localparam int DELTA_W  = DATA_W + 1;
  localparam int PPROD_W  = GAIN_W + 1 + DELTA_W;
  localparam int IPROD_W  = GAIN_W + 1 + DATA_W;
  localparam int PTERM_W  = PPROD_W - Q_SHIFT;
  localparam int ITERM_W  = IPROD_W - Q_SHIFT;
  localparam int SUM_W    = PTERM_W + 2;

  localparam logic signed [DATA_W-1:0] INTEG_ERR_CLAMP = 32'sd1310720;

  localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = '0;
  localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST = '0;
  localparam logic [LIMIT_W-1:0]       ERR_LIMIT_RST  = 31'h7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST    = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST    = 32'sh8000_0000;

  typedef enum logic [INDEX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_ERROR_LIMIT = 3'd2,
    REG_OUTPUT_MAX  = 3'd3,
    REG_OUTPUT_MIN  = 3'd4,
    REG_INTEG_MODE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [LIMIT_W-1:0]       error_limit;
    logic signed [DATA_W-1:0] output_max;
    logic signed [DATA_W-1:0] output_min;
    logic                     integ_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  err;
    logic signed [DATA_W-1:0]  ierr;
    logic signed [DELTA_W-1:0] delta;
  } err_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  err;
    logic signed [PTERM_W-1:0] pterm;
    logic signed [ITERM_W-1:0] iterm;
  } term_item_t;

endpackage
`default_nettype wire

// File: sv/ipr_error.sv
`default_nettype none
module ipr_error
  import ipr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] in_reference,
  input  wire logic signed [DATA_W-1:0] in_feedback,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output err_item_t                     out_data
);

  logic                        v0_r;
  logic                        v1_r;
  logic                        rdy0;
  logic                        rdy1;
  logic signed [DATA_W-1:0]    ref_r;
  logic signed [DATA_W-1:0]    fb_r;
  logic signed [DATA_W-1:0]    err_r;
  logic signed [DATA_W-1:0]    ierr_r;
  logic signed [DELTA_W-1:0]   delta_r;
  logic signed [DELTA_W-1:0]   diff;
  logic signed [DELTA_W-1:0]   lim_pos;
  logic signed [DELTA_W-1:0]   lim_neg;
  logic signed [DELTA_W-1:0]   diff_c;
  logic signed [DATA_W-1:0]    err_nxt;
  logic signed [DATA_W-1:0]    ierr_nxt;
  logic signed [DELTA_W-1:0]   delta_nxt;

  assign rdy1     = !v1_r || out_ready;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  always_comb begin
    diff    = {ref_r[DATA_W-1], ref_r} - {fb_r[DATA_W-1], fb_r};
    lim_pos = {{(DELTA_W-LIMIT_W){1'b0}}, cfg.error_limit};
    lim_neg = -lim_pos;
    diff_c  = diff;
    if (diff_c > lim_pos) begin
      diff_c = lim_pos;
    end
    if (diff_c < lim_neg) begin
      diff_c = lim_neg;
    end
    err_nxt  = diff_c[DATA_W-1:0];
    ierr_nxt = err_nxt;
    if (cfg.integ_mode) begin
      if (ierr_nxt > INTEG_ERR_CLAMP) begin
        ierr_nxt = INTEG_ERR_CLAMP;
      end
      if (ierr_nxt < -INTEG_ERR_CLAMP) begin
        ierr_nxt = -INTEG_ERR_CLAMP;
      end
    end
    delta_nxt = {err_nxt[DATA_W-1], err_nxt} - {err_r[DATA_W-1], err_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      ref_r <= in_reference;
      fb_r  <= in_feedback;
    end
  end

  // err_r doubles as the previous error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      err_r <= '0;
    end else if (rdy1) begin
      v1_r <= v0_r;
      if (v0_r) begin
        err_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      ierr_r  <= ierr_nxt;
      delta_r <= delta_nxt;
    end
  end

  assign out_valid      = v1_r;
  assign out_data.err   = err_r;
  assign out_data.ierr  = ierr_r;
  assign out_data.delta = delta_r;

endmodule
`default_nettype wire

// File: sv/ipr_gain.sv
`default_nettype none
module ipr_gain
  import ipr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire err_item_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output term_item_t     out_data
);

  logic                      v_r;
  logic                      rdy;
  term_item_t                term_r;
  term_item_t                term_nxt;
  logic signed [PPROD_W-1:0] pprod;
  logic signed [IPROD_W-1:0] iprod;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_comb begin
    pprod          = $signed({1'b0, cfg.prop_gain}) * in_data.delta;
    iprod          = $signed({1'b0, cfg.integ_gain}) * in_data.ierr;
    term_nxt.err   = in_data.err;
    term_nxt.pterm = pprod[PPROD_W-1:Q_SHIFT];
    term_nxt.iterm = iprod[IPROD_W-1:Q_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      term_r <= term_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = term_r;

endmodule
`default_nettype wire

// File: sv/ipr_accum.sv
`default_nettype none
module ipr_accum
  import ipr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire term_item_t           in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DATA_W-1:0]  out_drive,
  output logic signed [DATA_W-1:0]  out_error
);

  logic                      v_r;
  logic                      rdy;
  logic signed [DATA_W-1:0]  drive_r;
  logic signed [DATA_W-1:0]  err_r;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   hi;
  logic signed [SUM_W-1:0]   lo;
  logic signed [SUM_W-1:0]   sum_c;
  logic signed [DATA_W-1:0]  drive_nxt;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_comb begin
    sum = {{(SUM_W-DATA_W){drive_r[DATA_W-1]}}, drive_r}
        + {{(SUM_W-PTERM_W){in_data.pterm[PTERM_W-1]}}, in_data.pterm}
        + {{(SUM_W-ITERM_W){in_data.iterm[ITERM_W-1]}}, in_data.iterm};
    hi    = {{(SUM_W-DATA_W){cfg.output_max[DATA_W-1]}}, cfg.output_max};
    lo    = {{(SUM_W-DATA_W){cfg.output_min[DATA_W-1]}}, cfg.output_min};
    sum_c = sum;
    if (sum_c > hi) begin
      sum_c = hi;
    end
    if (sum_c < lo) begin
      sum_c = lo;
    end
    drive_nxt = sum_c[DATA_W-1:0];
  end

  // drive_r doubles as the accumulated output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      drive_r <= '0;
    end else if (rdy) begin
      v_r <= in_valid;
      if (in_valid) begin
        drive_r <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      err_r <= in_data.err;
    end
  end

  assign out_valid = v_r;
  assign out_drive = drive_r;
  assign out_error = err_r;

endmodule
`default_nettype wire

// File: sv/incremental_pi_regulator_top.sv
// Channel   Direction  Handshake                 Payload
// in_       slave      in_tvalid / in_tready     reference, feedback
// out_      master     out_tvalid / out_tready   drive, clamped_error
// cfg_      slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle sustained while out_tready stays high.
// Stages: input register, error clamp, gain multiply, accumulate and output clamp.
// Each stage holds its item only while the next one is full and stalled.
// rst_n is synchronous; it empties the pipe, zeroes previous error and accumulator,
// and loads register defaults. cfg_ready is always high.
`default_nettype none
module incremental_pi_regulator_top
  import ipr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [2*DATA_W-1:0]  in_tdata,    // [31:0] reference, [63:32] feedback
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [2*DATA_W-1:0]       out_tdata,   // [31:0] drive, [63:32] clamped_error
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [INDEX_W-1:0]   cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  cfg_t                     cfg_r;
  logic                     err_valid;
  logic                     err_ready;
  err_item_t                err_item;
  logic                     term_valid;
  logic                     term_ready;
  term_item_t               term_item;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] clamped_error;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= PROP_GAIN_RST;
      cfg_r.integ_gain  <= INTEG_GAIN_RST;
      cfg_r.error_limit <= ERR_LIMIT_RST;
      cfg_r.output_max  <= OUT_MAX_RST;
      cfg_r.output_min  <= OUT_MIN_RST;
      cfg_r.integ_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg_r.integ_gain  <= cfg_data[GAIN_W-1:0];
        REG_ERROR_LIMIT: cfg_r.error_limit <= cfg_data[LIMIT_W-1:0];
        REG_OUTPUT_MAX:  cfg_r.output_max  <= cfg_data;
        REG_OUTPUT_MIN:  cfg_r.output_min  <= cfg_data;
        REG_INTEG_MODE:  cfg_r.integ_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ipr_error u_error (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_reference (in_tdata[DATA_W-1:0]),
    .in_feedback  (in_tdata[2*DATA_W-1:DATA_W]),
    .out_valid    (err_valid),
    .out_ready    (err_ready),
    .out_data     (err_item)
  );

  ipr_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_data   (err_item),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .out_data  (term_item)
  );

  ipr_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (term_valid),
    .in_ready  (term_ready),
    .in_data   (term_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_drive (drive),
    .out_error (clamped_error)
  );

  assign out_tdata = {clamped_error, drive};

endmodule
`default_nettype wire

// File: sv/ipr_checker.sv
`default_nettype none
module ipr_checker
  import ipr_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tready,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [2*DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output side is free");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*DATA_W-1:DATA_W] != 32'h8000_0000)
    else $error("clamped error outside symmetric range");

endmodule

bind incremental_pi_regulator_top ipr_checker u_ipr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: test/testbench.sv
module testbench;
  import ipr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 4;
  localparam int IDLE_LIMIT   = 1000;
  localparam int REPORT_MAX   = 10;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic [INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] clamped_error;
  } regulator_out_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [2*DATA_W-1:0] in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [2*DATA_W-1:0] out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  cfg_index;
  logic [DATA_W-1:0]   cfg_data;

  regulator_out_t pending_outputs[$];
  int  mismatches;
  int  idle_cycles;
  bit  in_gaps;
  bit  out_stalls;

  longint kp, ki, err_lim, drive_max, drive_min;
  bit     integ_clamp_on;
  longint prev_err, drive_acc;

  incremental_pi_regulator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function void reset_regulator_model();
    kp             = 0;
    ki             = 0;
    err_lim        = longint'(ERR_LIMIT_RST);
    drive_max      = longint'(OUT_MAX_RST);
    drive_min      = longint'(OUT_MIN_RST);
    integ_clamp_on = 1'b0;
    prev_err       = 0;
    drive_acc      = 0;
  endfunction

  function void apply_register(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_PROP_GAIN:   kp = longint'(value[GAIN_W-1:0]);
      REG_INTEG_GAIN:  ki = longint'(value[GAIN_W-1:0]);
      REG_ERROR_LIMIT: err_lim = longint'(value[LIMIT_W-1:0]);
      REG_OUTPUT_MAX:  drive_max = longint'($signed(value));
      REG_OUTPUT_MIN:  drive_min = longint'($signed(value));
      REG_INTEG_MODE:  integ_clamp_on = value[0];
      default: ;
    endcase
  endfunction

  function regulator_out_t regulate_sample(input logic signed [DATA_W-1:0] ref_val,
                                           input logic signed [DATA_W-1:0] fb_val);
    longint err, ierr, pterm, iterm, sum;
    regulator_out_t res;
    err = longint'(ref_val) - longint'(fb_val);
    if (err > err_lim) err = err_lim;
    if (err < -err_lim) err = -err_lim;
    ierr = err;
    if (integ_clamp_on) begin
      if (ierr > longint'(INTEG_ERR_CLAMP)) ierr = longint'(INTEG_ERR_CLAMP);
      if (ierr < -longint'(INTEG_ERR_CLAMP)) ierr = -longint'(INTEG_ERR_CLAMP);
    end
    pterm = (kp * (err - prev_err)) >>> Q_SHIFT;
    iterm = (ki * ierr) >>> Q_SHIFT;
    sum = drive_acc + pterm + iterm;
    if (sum > drive_max) sum = drive_max;
    if (sum < drive_min) sum = drive_min;
    prev_err = err;
    drive_acc = sum;
    res.drive = sum[DATA_W-1:0];
    res.clamped_error = err[DATA_W-1:0];
    return res;
  endfunction

  // Tasks start and end at a falling edge.
  task automatic send_sample(input logic signed [DATA_W-1:0] ref_val,
                             input logic signed [DATA_W-1:0] fb_val);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {fb_val, ref_val};
    do @(posedge clk); while (!in_tready);
    pending_outputs.push_back(regulate_sample(ref_val, fb_val));
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_tvalid = 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_register(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
    drain_pipe();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [DATA_W-1:0] pg, input logic [DATA_W-1:0] ig,
                           input logic [DATA_W-1:0] lim, input logic [DATA_W-1:0] omax,
                           input logic [DATA_W-1:0] omin, input logic [DATA_W-1:0] mode);
    write_register(REG_PROP_GAIN, pg);
    write_register(REG_INTEG_GAIN, ig);
    write_register(REG_ERROR_LIMIT, lim);
    write_register(REG_OUTPUT_MAX, omax);
    write_register(REG_OUTPUT_MIN, omin);
    write_register(REG_INTEG_MODE, mode);
  endtask

  task automatic test_reset_state();
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MIN, Q_MAX);
    send_sample(0, 0);
  endtask

  task automatic test_full_gains();
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Q_MAX, Q_MIN, 0);
    send_sample(1, 0);
    send_sample(-1, 0);
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MIN, Q_MAX);
    send_sample(0, 0);
  endtask

  task automatic test_zero_error_limit();
    write_register(REG_ERROR_LIMIT, 0);
    send_sample(Q_MAX, 0);
    send_sample(5, 3);
  endtask

  task automatic test_integral_clamp();
    write_all(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, Q_MAX, Q_MIN, 1);
    send_sample(32'sd1310721, 0);
    send_sample(-32'sd1310721, 0);
    send_sample(INTEG_ERR_CLAMP, 0);
    send_sample(100, 0);
  endtask

  task automatic test_output_limits();
    write_register(REG_OUTPUT_MAX, -32'sd100);
    write_register(REG_OUTPUT_MIN, 32'sd100);
    send_sample(32'sd70000, 0);
    send_sample(-32'sd70000, 0);
    write_register(REG_OUTPUT_MAX, 32'sd5);
    write_register(REG_OUTPUT_MIN, 32'sd5);
    send_sample(Q_MAX, Q_MIN);
    write_register(REG_OUTPUT_MAX, Q_MAX);
    write_register(REG_OUTPUT_MIN, Q_MIN);
  endtask

  task automatic test_spare_index();
    write_register(REG_SPARE_6, 32'hFFFF_FFFF);
    write_register(REG_SPARE_7, 32'hFFFF_FFFF);
    send_sample(32'sd1000, 32'sd10);
    send_sample(-32'sd1000, 32'sd10);
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 131071);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 4194304);
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_sample(output logic signed [DATA_W-1:0] ref_val,
                             output logic signed [DATA_W-1:0] fb_val);
    case ($urandom_range(0, 3))
      0: begin
        ref_val = $urandom;
        fb_val  = $urandom;
      end
      1: begin
        ref_val = $urandom_range(0, 2097152) - 1048576;
        fb_val  = $urandom_range(0, 2097152) - 1048576;
      end
      2: begin
        fb_val  = $urandom_range(0, 65535) - 32768;
        ref_val = fb_val + ($urandom_range(0, 1) ? INTEG_ERR_CLAMP : -INTEG_ERR_CLAMP)
                  + $urandom_range(0, 8) - 4;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       ref_val = Q_MAX;
          1:       ref_val = Q_MIN;
          2:       ref_val = 0;
          default: ref_val = -1;
        endcase
        fb_val = $urandom_range(0, 1) ? Q_MIN : $urandom;
      end
    endcase
  endtask

  task automatic test_random_phases();
    logic signed [DATA_W-1:0] r, f, hi, lo;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 2))
        0: begin
          hi = Q_MAX;
          lo = Q_MIN;
        end
        1: begin
          hi = $urandom;
          lo = $urandom;
        end
        default: begin
          hi = $urandom_range(0, 16777216);
          lo = -$urandom_range(0, 16777216);
        end
      endcase
      write_all(pick_gain(), pick_gain(), pick_limit(), hi, lo, $urandom);
      if ($urandom_range(0, 3) == 0)
        write_register($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
      in_gaps    = $urandom_range(0, 2) != 0;
      out_stalls = $urandom_range(0, 2) != 0;
      repeat (190) begin
        pick_sample(r, f);
        send_sample(r, f);
      end
    end
  endtask

  task automatic test_back_to_back();
    logic signed [DATA_W-1:0] r, f;
    write_all(32'h0000_8000, 32'h0000_0400, 32'h0010_0000, 32'sh0100_0000, -32'sh0100_0000, 0);
    in_gaps    = 1'b0;
    out_stalls = 1'b0;
    repeat (100) begin
      pick_sample(r, f);
      send_sample(r, f);
    end
  endtask

  task automatic finish_run();
    drain_pipe();
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("incremental_pi_regulator_top: match");
    end else begin
      $display("incremental_pi_regulator_top: mismatch");
    end
    $finish;
  endtask

  always begin
    @(negedge clk);
    if (out_stalls && $urandom_range(0, 4) == 0) begin
      out_tready = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    out_tready = 1'b1;
  end

  always @(posedge clk) begin : check_outputs
    regulator_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected item: drive %0d clamped_error %0d",
                   $signed(out_tdata[DATA_W-1:0]), $signed(out_tdata[2*DATA_W-1:DATA_W]));
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata[DATA_W-1:0] !== want.drive ||
            out_tdata[2*DATA_W-1:DATA_W] !== want.clamped_error) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("item mismatch: drive %0d (want %0d), clamped_error %0d (want %0d)",
                     $signed(out_tdata[DATA_W-1:0]), want.drive,
                     $signed(out_tdata[2*DATA_W-1:DATA_W]), want.clamped_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("incremental_pi_regulator_top: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_gaps     = 1'b1;
    out_stalls  = 1'b1;
    mismatches  = 0;
    idle_cycles = 0;
    reset_regulator_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_full_gains();
    test_zero_error_limit();
    test_integral_clamp();
    test_output_limits();
    test_spare_index();
    test_random_phases();
    test_back_to_back();
    finish_run();
  end

endmodule
